// ----- rtl/odu_pkg.sv -----
`default_nettype none

package odu_pkg;

   // operation codes carried in the request tuser
   typedef enum logic [2:0] {
      FUNC_MD_TO_DOY = 3'd0,
      FUNC_DOY_TO_MD = 3'd1,
      FUNC_ADD_DAYS  = 3'd2,
      FUNC_SUB_DAYS  = 3'd3,
      FUNC_BETWEEN   = 3'd4
   } func_type;

   // field widths
   localparam int unsigned FUNC_W  = 3;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned DOY_W   = 9;
   localparam int unsigned COUNT_W = 11;

   // request tdata layout, lowest bits first
   localparam int unsigned REQ_YEAR_LSB  = 0;
   localparam int unsigned REQ_MONTH_LSB = REQ_YEAR_LSB + YEAR_W;
   localparam int unsigned REQ_DAY_LSB   = REQ_MONTH_LSB + MONTH_W;
   localparam int unsigned REQ_DOY_LSB   = REQ_DAY_LSB + DAY_W;
   localparam int unsigned REQ_OFFS_LSB  = REQ_DOY_LSB + DOY_W;
   localparam int unsigned REQ_EYEAR_LSB = REQ_OFFS_LSB + DOY_W;
   localparam int unsigned REQ_EDOY_LSB  = REQ_EYEAR_LSB + YEAR_W;
   localparam int unsigned REQ_DATA_W    = 64;

   // response tdata layout, lowest bits first
   localparam int unsigned RSP_YEAR_LSB  = 0;
   localparam int unsigned RSP_DOY_LSB   = RSP_YEAR_LSB + YEAR_W;
   localparam int unsigned RSP_MONTH_LSB = RSP_DOY_LSB + DOY_W;
   localparam int unsigned RSP_DAY_LSB   = RSP_MONTH_LSB + MONTH_W;
   localparam int unsigned RSP_COUNT_LSB = RSP_DAY_LSB + DAY_W;
   localparam int unsigned RSP_USED_W    = RSP_COUNT_LSB + COUNT_W;
   localparam int unsigned RSP_DATA_W    = 48;

   // year lengths and month limits
   localparam logic [9:0] COMMON_YEAR_LEN = 10'd365;
   localparam logic [8:0] LEAP_YEAR_LEN   = 9'd366;
   localparam logic [8:0] JAN_LAST_PLUS   = 9'd32;
   localparam logic [8:0] FEB_END_COMMON  = 9'd60;
   localparam logic [8:0] JAN_DAYS        = 9'd31;
   localparam logic [4:0] FEB_LEAP_DAY    = 5'd29;
   localparam logic [3:0] MONTH_JAN       = 4'd1;
   localparam logic [3:0] MONTH_FEB       = 4'd2;
   localparam logic [3:0] MONTH_MAR       = 4'd3;
   localparam logic [3:0] MONTH_DEC       = 4'd12;

   // divisibility by 25 through the modular inverse of 25 mod 2**14:
   // y*inv mod 2**14 lands at or below 16383/25 exactly for multiples of 25
   localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
   localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

   // gregorian leap rule: by 4 and not by 100, or by 400
   function automatic logic is_leap_f(input logic [YEAR_W-1:0] y);
      logic [YEAR_W-1:0] prod;
      logic              div25;
      prod  = y * INV25;
      div25 = (prod <= DIV25_LIMIT);
      return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
   endfunction

   // days in the year before the first of the given month, 0 for bad months
   function automatic logic [DOY_W-1:0] days_before_f(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] d;
      unique case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ordinal_date_unit.sv -----
// Gregorian day-of-year arithmetic on a request/response stream.
// Requests enter on req_tvalid/req_tready with the operation code on req_tuser
// (0 month/day to day-of-year, 1 day-of-year to month/day, 2 add days,
// 3 subtract days, 4 inclusive days between) and the date fields on req_tdata.
// Each request yields exactly one response on rsp_tvalid/rsp_tready, with the
// error flag on rsp_tuser and the results on rsp_tdata.
// An accepted request is held in the input register and passes from there
// through one pass of leap test, month table and add/compare logic into the
// response register, which drives rsp_tvalid. Throughput is one request per
// cycle while the receiver does not stall; the leap test multiplies this year
// and the year before each by the inverse of 25 in 14 bits.
// When the receiver stalls, the response holds and one more request can wait
// in the input register; req_tready drops only when both are full.
// Reset (synchronous, active high) empties both registers; any request in
// flight is dropped. There is no configuration and no other state.
`default_nettype none

module ordinal_date_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // year[13:0], month[17:14], day[22:18], day_of_year[31:23],
   // offset_days[40:32], stop_year[54:41], end_day_of_year[63:55]
   input  wire logic [odu_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func[2:0]
   input  wire logic [odu_pkg::FUNC_W-1:0]       req_tuser,
   // response channel
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // result_year[13:0], result_day_of_year[22:14], result_month[26:23],
   // result_day[31:27], day_count[42:32], zero[47:43]
   output      logic [odu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // error[0]
   output      logic                             rsp_tuser
);
   import odu_pkg::*;

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   logic [REQ_DATA_W-1:0] s1_data_ff;
   logic [FUNC_W-1:0]     s1_func_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic req_fire;
   logic rsp_load;

   // handshake and register enables
   assign rsp_load   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || rsp_load;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (rsp_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // request field unpack
   logic [YEAR_W-1:0]  f_year, f_eyear;
   logic [MONTH_W-1:0] f_month;
   logic [DAY_W-1:0]   f_day;
   logic [DOY_W-1:0]   f_doy, f_offs, f_edoy;

   assign f_year  = s1_data_ff[REQ_YEAR_LSB  +: YEAR_W];
   assign f_month = s1_data_ff[REQ_MONTH_LSB +: MONTH_W];
   assign f_day   = s1_data_ff[REQ_DAY_LSB   +: DAY_W];
   assign f_doy   = s1_data_ff[REQ_DOY_LSB   +: DOY_W];
   assign f_offs  = s1_data_ff[REQ_OFFS_LSB  +: DOY_W];
   assign f_eyear = s1_data_ff[REQ_EYEAR_LSB +: YEAR_W];
   assign f_edoy  = s1_data_ff[REQ_EDOY_LSB  +: DOY_W];

   // leap flags of this year and the year before
   logic              leap, prev_leap;
   logic [YEAR_W-1:0] year_dec, year_inc;

   assign year_dec  = f_year - YEAR_W'(1);
   assign year_inc  = f_year + YEAR_W'(1);
   assign leap      = is_leap_f(f_year);
   assign prev_leap = (f_year == '0) ? 1'b0 : is_leap_f(year_dec);

   // month search for day-of-year to month/day: thresholds rise, so the
   // number of month ends below the day picks the month
   logic [MONTH_W-1:0] late_month;
   logic [DOY_W-1:0]   late_day;

   always_comb begin
      logic [MONTH_W-1:0] passed;
      passed = '0;
      for (int k = 3; k <= 12; k++) begin
         if ({1'b0, f_doy} > ({1'b0, days_before_f(MONTH_W'(k))} + 10'(leap))) begin
            passed = passed + MONTH_W'(1);
         end
      end
      late_month = MONTH_FEB + passed;
      late_day   = f_doy - days_before_f(late_month) - DOY_W'(leap);
   end

   // operation datapath
   logic [YEAR_W-1:0]  r_year;
   logic [DOY_W-1:0]   r_doy;
   logic [MONTH_W-1:0] r_month;
   logic [DAY_W-1:0]   r_day;
   logic [COUNT_W-1:0] r_count;
   logic               r_err;

   always_comb begin
      logic [9:0]         sum;
      logic [9:0]         len;
      logic [10:0]        diff;
      logic               doy_bad;
      r_year  = f_year;
      r_doy   = '0;
      r_month = '0;
      r_day   = '0;
      r_count = '0;
      r_err   = 1'b0;
      len     = COMMON_YEAR_LEN + 10'(leap);
      sum     = 10'(f_doy) + 10'(f_offs);
      diff    = 11'(f_doy) - 11'(f_offs);
      doy_bad = (f_doy > LEAP_YEAR_LEN);
      unique case (s1_func_ff)
         FUNC_MD_TO_DOY: begin
            if (f_month >= MONTH_JAN && f_month <= MONTH_DEC) begin
               r_doy = DOY_W'(f_day) + days_before_f(f_month)
                       + DOY_W'(leap && (f_month >= MONTH_MAR));
            end else begin
               r_err = 1'b1;
            end
         end
         FUNC_DOY_TO_MD: begin
            priority if (doy_bad || (f_doy == LEAP_YEAR_LEN && !leap)) begin
               r_err = 1'b1;
            end else if (f_doy < JAN_LAST_PLUS) begin
               r_month = MONTH_JAN;
               r_day   = f_doy[DAY_W-1:0];
            end else if (f_doy < FEB_END_COMMON) begin
               r_month = MONTH_FEB;
               r_day   = DAY_W'(f_doy - JAN_DAYS);
            end else if (leap && f_doy == FEB_END_COMMON) begin
               r_month = MONTH_FEB;
               r_day   = FEB_LEAP_DAY;
            end else begin
               r_month = late_month;
               r_day   = late_day[DAY_W-1:0];
            end
         end
         FUNC_ADD_DAYS: begin
            r_err = doy_bad;
            if (sum > len) begin
               r_doy  = DOY_W'(sum - len);
               r_year = year_inc;
            end else begin
               r_doy = sum[DOY_W-1:0];
            end
         end
         FUNC_SUB_DAYS: begin
            r_err = doy_bad;
            if (diff[10] || diff == '0) begin
               r_doy  = DOY_W'(diff + 11'(COMMON_YEAR_LEN) + 11'(prev_leap));
               r_year = year_dec;
            end else begin
               r_doy = diff[DOY_W-1:0];
            end
         end
         FUNC_BETWEEN: begin
            r_err = doy_bad || (f_edoy > LEAP_YEAR_LEN);
            if (f_year == f_eyear) begin
               r_count = 11'(f_edoy) - 11'(f_doy) + 11'd1;
            end else begin
               r_count = 11'(len) - 11'(f_doy) + 11'd1 + 11'(f_edoy);
            end
         end
         default: begin
            r_err = 1'b1;
         end
      endcase
   end

   // response pack
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_YEAR_LSB  +: YEAR_W]  = r_year;
      rsp_data_in[RSP_DOY_LSB   +: DOY_W]   = r_doy;
      rsp_data_in[RSP_MONTH_LSB +: MONTH_W] = r_month;
      rsp_data_in[RSP_DAY_LSB   +: DAY_W]   = r_day;
      rsp_data_in[RSP_COUNT_LSB +: COUNT_W] = r_count;
      rsp_err_in = r_err;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_tdata;
         s1_func_ff <= req_tuser;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   // a full input register behind a stalled response blocks new requests
   a_block_when_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while both registers are full");

   // a waiting request always lands in the response register
   a_load_lands: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("loaded response not valid");

   // month/day results never share a response with day-of-year or count
   a_month_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[RSP_MONTH_LSB +: MONTH_W] != '0) |->
      (rsp_data_ff[RSP_DOY_LSB +: DOY_W] == '0 &&
       rsp_data_ff[RSP_COUNT_LSB +: COUNT_W] == '0))
      else $error("month result mixed with other results");

   // month result stays within the calendar
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[RSP_MONTH_LSB +: MONTH_W] <= MONTH_DEC))
      else $error("month result out of range");

   // padding bits above the used fields stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[RSP_DATA_W-1:RSP_USED_W] == '0))
      else $error("response padding not zero");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
   import odu_pkg::*;

   // request payload, last field first so that year lands in the low bits
   typedef struct packed {
      logic [DOY_W-1:0]   end_doy;
      logic [YEAR_W-1:0]  stop_year;
      logic [DOY_W-1:0]   offset_days;
      logic [DOY_W-1:0]   doy;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_req_type;

   // response payload, same convention
   typedef struct packed {
      logic [4:0]         pad;
      logic [COUNT_W-1:0] day_count;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [DOY_W-1:0]   doy;
      logic [YEAR_W-1:0]  year;
   } date_rsp_type;

   typedef struct {
      logic [YEAR_W-1:0]  year;
      logic [DOY_W-1:0]   doy;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [COUNT_W-1:0] day_count;
      logic               error;
   } date_answer_type;

   // operation codes the block does not define
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   localparam int unsigned RANDOM_ITEMS = 600;
   localparam int unsigned DRAIN_CYCLES = 8;

   // first day of each month minus one, common year
   localparam logic [8:0] MONTH_START [0:11] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // expected date results, in request order
   class date_scoreboard;
      date_answer_type pending_answers[$];
      int unsigned     fail_count;

      function new();
         fail_count = 0;
      endfunction

      function int unsigned leap_year(int unsigned y);
         return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 1 : 0;
      endfunction

      function date_answer_type compute_answer(logic [FUNC_W-1:0] func, date_req_type r);
         date_answer_type a;
         int unsigned     lp;
         int unsigned     prev_lp;
         int unsigned     sum;
         int unsigned     m;
         int              diff;
         int              cnt;
         a.year      = r.year;
         a.doy       = '0;
         a.month     = '0;
         a.day       = '0;
         a.day_count = '0;
         a.error     = 1'b0;
         lp = leap_year(r.year);
         case (func)
            FUNC_MD_TO_DOY: begin
               if (r.month >= MONTH_JAN && r.month <= MONTH_DEC) begin
                  sum = r.day + MONTH_START[r.month - 1] + ((r.month >= MONTH_MAR) ? lp : 0);
                  a.doy = 9'(sum);
               end else begin
                  a.error = 1'b1;
               end
            end
            FUNC_DOY_TO_MD: begin
               if (r.doy > 366 || (r.doy == 366 && lp == 0)) begin
                  a.error = 1'b1;
               end else if (r.doy < 32) begin
                  a.month = MONTH_JAN;
                  a.day   = 5'(r.doy);
               end else if (r.doy < 60) begin
                  a.month = MONTH_FEB;
                  a.day   = 5'(r.doy - 31);
               end else if (lp != 0 && r.doy == 60) begin
                  // leap day
                  a.month = MONTH_FEB;
                  a.day   = 5'd29;
               end else begin
                  m = 2;
                  while (m < 12 && r.doy > MONTH_START[m] + lp)
                     m++;
                  a.month = 4'(m);
                  a.day   = 5'(r.doy - MONTH_START[m - 1] - lp);
               end
            end
            FUNC_ADD_DAYS: begin
               sum = r.doy + r.offset_days;
               if (r.doy > 366)
                  a.error = 1'b1;
               // one rollover at most, year wraps at the field width
               if (sum > 365 + lp) begin
                  sum    = sum - (365 + lp);
                  a.year = r.year + 1'b1;
               end
               a.doy = 9'(sum);
            end
            FUNC_SUB_DAYS: begin
               diff    = int'(r.doy) - int'(r.offset_days);
               prev_lp = (r.year == 0) ? 0 : leap_year(r.year - 1);
               if (r.doy > 366)
                  a.error = 1'b1;
               if (diff <= 0) begin
                  diff   = diff + 365 + int'(prev_lp);
                  a.year = r.year - 1'b1;
               end
               a.doy = 9'(diff);
            end
            FUNC_BETWEEN: begin
               if (r.doy > 366 || r.end_doy > 366)
                  a.error = 1'b1;
               // any other end year counts as the following year
               if (r.year == r.stop_year)
                  cnt = int'(r.end_doy) - int'(r.doy) + 1;
               else
                  cnt = 365 + int'(lp) - int'(r.doy) + 1 + int'(r.end_doy);
               a.day_count = 11'(cnt);
            end
            default: begin
               a.error = 1'b1;
            end
         endcase
         return a;
      endfunction

      function void note_request(logic [FUNC_W-1:0] func, date_req_type r);
         pending_answers.push_back(compute_answer(func, r));
      endfunction

      function void match_field(string name, int expected, int actual);
         if (expected != actual) begin
            $error("%s expected %0d actual %0d", name, expected, actual);
            fail_count++;
         end
      endfunction

      function void check_response(date_rsp_type d, logic err);
         date_answer_type a;
         if (pending_answers.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            a = pending_answers.pop_front();
            match_field("result_year", a.year, d.year);
            match_field("result_day_of_year", a.doy, d.doy);
            match_field("result_month", a.month, d.month);
            match_field("result_day", a.day, d.day);
            match_field("day_count", int'($signed(a.day_count)), int'($signed(d.day_count)));
            match_field("error", a.error, err);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [FUNC_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   date_scoreboard sb;
   int unsigned    req_idle_pct;

   ordinal_date_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(date_rsp_type'(rsp_tdata), rsp_tuser);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, date_req_type'(req_tdata));
      end
   end

   // offer one request, return at the falling edge after it is taken
   task automatic send_request(input logic [FUNC_W-1:0] func, input date_req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      req_tuser  <= func;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [FUNC_W-1:0] func, input int unsigned year,
                              input int unsigned month, input int unsigned day,
                              input int unsigned doy, input int unsigned offset_days,
                              input int unsigned stop_year, input int unsigned end_doy);
      date_req_type r;
      r.year        = YEAR_W'(year);
      r.month       = MONTH_W'(month);
      r.day         = DAY_W'(day);
      r.doy         = DOY_W'(doy);
      r.offset_days = DOY_W'(offset_days);
      r.stop_year   = YEAR_W'(stop_year);
      r.end_doy     = DOY_W'(end_doy);
      send_request(func, r);
   endtask

   // receiver: random stalls, one long hold-off, no stalls while the sender
   // runs without gaps
   initial begin : rsp_side
      int unsigned cyc;
      cyc        = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc >= 300 && cyc < 380)
            rsp_tready <= 1'b0;
         else if (req_idle_pct == 0)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ($urandom_range(99) >= 15);
      end
   end

   // run limit
   initial begin
      #3_000_000;
      $display("ordinal_date_unit: mismatch");
      $finish;
   end

   initial begin : stimulus
      date_req_type      r;
      logic [FUNC_W-1:0] func;
      int unsigned       pick;
      sb           = new();
      req_idle_pct = 15;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // month/day to day of year, including bad months
      send_fields(FUNC_MD_TO_DOY, 2023, 1, 1, 0, 0, 0, 0);
      send_fields(FUNC_MD_TO_DOY, 2000, 12, 31, 0, 0, 0, 0);
      send_fields(FUNC_MD_TO_DOY, 2024, 3, 1, 0, 0, 0, 0);
      send_fields(FUNC_MD_TO_DOY, 1900, 3, 1, 0, 0, 0, 0);
      send_fields(FUNC_MD_TO_DOY, 2024, 0, 31, 0, 0, 0, 0);
      send_fields(FUNC_MD_TO_DOY, 2024, 15, 1, 0, 0, 0, 0);
      // day of year to month/day: leap day, day 366 both ways, day 0, out of range
      send_fields(FUNC_DOY_TO_MD, 2024, 0, 0, 60, 0, 0, 0);
      send_fields(FUNC_DOY_TO_MD, 2023, 0, 0, 366, 0, 0, 0);
      send_fields(FUNC_DOY_TO_MD, 2000, 0, 0, 366, 0, 0, 0);
      send_fields(FUNC_DOY_TO_MD, 2100, 0, 0, 335, 0, 0, 0);
      send_fields(FUNC_DOY_TO_MD, 1999, 0, 0, 0, 0, 0, 0);
      send_fields(FUNC_DOY_TO_MD, 1999, 0, 0, 511, 0, 0, 0);
      // add with rollover, top year wrapping, out-of-range day
      send_fields(FUNC_ADD_DAYS, 2023, 0, 0, 365, 365, 0, 0);
      send_fields(FUNC_ADD_DAYS, 16383, 0, 0, 200, 300, 0, 0);
      send_fields(FUNC_ADD_DAYS, 2024, 0, 0, 400, 0, 0, 0);
      // subtract with year zero wrapping and a leap previous year
      send_fields(FUNC_SUB_DAYS, 0, 0, 0, 1, 1, 0, 0);
      send_fields(FUNC_SUB_DAYS, 2001, 0, 0, 365, 365, 0, 0);
      send_fields(FUNC_SUB_DAYS, 2024, 0, 0, 366, 0, 0, 0);
      // days between: same year, next year, far year, bad end day
      send_fields(FUNC_BETWEEN, 2024, 0, 0, 366, 0, 2024, 1);
      send_fields(FUNC_BETWEEN, 2024, 0, 0, 366, 0, 2025, 1);
      send_fields(FUNC_BETWEEN, 1900, 0, 0, 1, 0, 9999, 366);
      send_fields(FUNC_BETWEEN, 2023, 0, 0, 500, 0, 2023, 511);
      // undefined codes
      send_fields(FUNC_SPARE_LO, 1234, 5, 6, 7, 8, 9, 10);
      send_fields(FUNC_SPARE_HI, 16383, 15, 31, 511, 365, 16383, 511);

      // random requests
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         req_idle_pct = (i >= 300 && i < 420) ? 0 : 15;
         if ($urandom_range(99) < 5)
            func = FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
         else
            func = FUNC_W'($urandom_range(FUNC_BETWEEN, FUNC_MD_TO_DOY));
         // years near the leap rule boundaries as well as plain ones
         pick = $urandom_range(9);
         case (pick)
            0:       r.year = YEAR_W'(400 * $urandom_range(24));
            1:       r.year = YEAR_W'(100 * $urandom_range(99));
            2:       r.year = YEAR_W'(4 * $urandom_range(2499));
            3:       r.year = YEAR_W'($urandom_range(1) ? 16383 : 0);
            default: r.year = YEAR_W'($urandom_range(9999));
         endcase
         r.month = ($urandom_range(99) < 90) ? MONTH_W'($urandom_range(12, 1))
                                             : MONTH_W'($urandom_range(15));
         r.day   = DAY_W'($urandom_range(31));
         r.doy   = ($urandom_range(99) < 85) ? DOY_W'($urandom_range(366, 1))
                                             : DOY_W'($urandom_range(511));
         r.offset_days = DOY_W'($urandom_range(365));
         pick = $urandom_range(99);
         if (pick < 45)
            r.stop_year = r.year;
         else if (pick < 90)
            r.stop_year = r.year + 1'b1;
         else
            r.stop_year = YEAR_W'($urandom_range(9999));
         r.end_doy = ($urandom_range(99) < 90) ? DOY_W'($urandom_range(366, 1))
                                               : DOY_W'($urandom_range(511));
         send_request(func, r);
      end
      req_tvalid <= 1'b0;

      // drain
      while (sb.pending_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending_answers.size() == 0)
         $display("ordinal_date_unit: match");
      else
         $display("ordinal_date_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
